// File: rtl/slab_size_class_allocator_defines.svh
// Assertion macros used by the slab allocator checker.
// No dependencies; include by bare file name.
`ifndef SLAB_SIZE_CLASS_ALLOCATOR_DEFINES_SVH
`define SLAB_SIZE_CLASS_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, quiet during reset.
`define SLAB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("slab check failed");

// Next-cycle implication, sampled on aclk, quiet during reset.
`define SLAB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("slab check failed");

`endif

// File: rtl/slab_pkg.sv
// Shared types and constants for the slab size class allocator.
// No dependencies.
package slab_pkg;

    localparam int ADDR_W = 48;
    localparam int REQ_W  = 32;
    localparam int SIZE_W = 19;
    localparam int OP_W   = 2;
    localparam int CLS_OUT_W = 2;
    localparam int STAT_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_SIZES = 4;

    localparam int DEF_CLASSES      = 4;
    localparam int DEF_REGION_BYTES = 262144;
    localparam int DEF_MAX_CHUNKS   = 16384;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LAST  = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO_SIZE = 3'd1,
        ST_NO_FIT    = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ALLOC_SEL,
        S_ALLOC_DATA,
        S_FREE_SEL,
        S_FREE_PUSH,
        S_RESP
    } state_t;

endpackage

// File: rtl/slab_size_class_allocator.sv
// Top level of the slab size class allocator: free queue memory and sequencer.
// Depends on slab_pkg.
//
// One operation at a time. Allocate steps through accept, class pick and queue
// memory read, address add, and response, skipping the address add when the
// size is zero or nothing fits. Free steps through offset subtract, class pick,
// range check and queue write, and response, skipping the range check and queue
// write when the address lies past the last region. Opcode three goes from
// accept straight to response. Initialize writes the queue memory one chunk per
// cycle and closes each class's queue when its chunks are written, then it
// responds. A result waiting in the output register does not hold back the
// next input beat.
module slab_size_class_allocator #(
    parameter int CLASSES      = slab_pkg::DEF_CLASSES,
    parameter int REGION_BYTES = slab_pkg::DEF_REGION_BYTES,
    parameter int MAX_CHUNKS   = slab_pkg::DEF_MAX_CHUNKS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [slab_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [slab_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [slab_pkg::OP_W-1:0]      s_opcode,
    input  logic [slab_pkg::REQ_W-1:0]     s_req_size,
    input  logic [slab_pkg::ADDR_W-1:0]    s_free_addr,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_ok,
    output logic [slab_pkg::ADDR_W-1:0]    m_out_addr,
    output logic [slab_pkg::CLS_OUT_W-1:0] m_class_index,
    output logic [slab_pkg::STAT_W-1:0]    m_status
);
    import slab_pkg::*;

    localparam int CLS_W = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int PW    = $clog2(MAX_CHUNKS);
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int DEPTH = CLASSES * MAX_CHUNKS;
    localparam int AW    = $clog2(DEPTH);
    localparam int OFF_W = $clog2(REGION_BYTES);
    localparam int END_W = $clog2(REGION_BYTES + 1);
    localparam int SUM_W = ((END_W > SIZE_W) ? END_W : SIZE_W) + 1;

    // configuration
    logic [ADDR_W-1:0] heap_base_reg;
    logic [SIZE_W-1:0] cfg_size_reg [CFG_SIZES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
            for (int i = 0; i < CFG_SIZES; i++) begin
                cfg_size_reg[i] <= SIZE_W'(16 << i);
            end
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_HEAP_BASE) begin
                heap_base_reg <= cfg_wdata;
            end else if (cfg_index >= CFG_SIZE_FIRST && cfg_index <= CFG_SIZE_LAST) begin
                cfg_size_reg[2'(cfg_index - CFG_SIZE_FIRST)] <= cfg_wdata[SIZE_W-1:0];
            end
        end
    end

    function automatic logic [SIZE_W-1:0] size_of(input logic [CLS_W-1:0] c);
        logic [SIZE_W-1:0] s;
        s = '0;
        for (int i = 0; i < CLASSES; i++) begin
            if (CLS_W'(i) == c) begin
                s = (i < CFG_SIZES) ? cfg_size_reg[i % CFG_SIZES] : SIZE_W'(16 << i);
            end
        end
        return s;
    endfunction

    function automatic logic [AW-1:0] mem_base(input logic [CLS_W-1:0] c);
        return AW'(c) * AW'(MAX_CHUNKS);
    endfunction

    function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
        return (p == PW'(MAX_CHUNKS - 1)) ? '0 : p + 1'b1;
    endfunction

    // free queue memory
    logic [OFF_W-1:0] mem [DEPTH];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [OFF_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [OFF_W-1:0] mem_q;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    // queue control
    state_t            state_reg, state_next;
    logic [PW-1:0]     head_reg [CLASSES];
    logic [PW-1:0]     head_next [CLASSES];
    logic [PW-1:0]     tail_reg [CLASSES];
    logic [PW-1:0]     tail_next [CLASSES];
    logic [CNT_W-1:0]  count_reg [CLASSES];
    logic [CNT_W-1:0]  count_next [CLASSES];
    logic [END_W-1:0]  end_reg [CLASSES];
    logic [END_W-1:0]  end_next [CLASSES];

    logic [REQ_W-1:0]  req_reg, req_next;
    logic [ADDR_W-1:0] off_reg, off_next;
    logic [OFF_W-1:0]  within_reg, within_next;
    logic [CLS_W-1:0]  cls_reg, cls_next;
    logic [END_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  k_reg, k_next;

    logic              res_ok_reg, res_ok_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next;
    logic [CLS_W-1:0]  res_cls_reg, res_cls_next;
    status_t           res_status_reg, res_status_next;

    logic              m_valid_reg, m_valid_next;
    logic              m_ok_reg, m_ok_next;
    logic [ADDR_W-1:0] m_addr_reg, m_addr_next;
    logic [CLS_W-1:0]  m_cls_reg, m_cls_next;
    status_t           m_status_reg, m_status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < CLASSES; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
                end_reg[i]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            end_reg     <= end_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        off_reg        <= off_next;
        within_reg     <= within_next;
        cls_reg        <= cls_next;
        acc_reg        <= acc_next;
        k_reg          <= k_next;
        res_ok_reg     <= res_ok_next;
        res_addr_reg   <= res_addr_next;
        res_cls_reg    <= res_cls_next;
        res_status_reg <= res_status_next;
        m_ok_reg       <= m_ok_next;
        m_addr_reg     <= m_addr_next;
        m_cls_reg      <= m_cls_next;
        m_status_reg   <= m_status_next;
    end

    // class picks
    logic             alloc_hit;
    logic [CLS_W-1:0] alloc_cls;
    logic             free_hit;
    logic [CLS_W-1:0] free_cls;

    always_comb begin
        alloc_hit = 1'b0;
        alloc_cls = '0;
        for (int i = CLASSES - 1; i >= 0; i--) begin
            if (REQ_W'(size_of(CLS_W'(i))) >= req_reg && count_reg[i] != '0) begin
                alloc_hit = 1'b1;
                alloc_cls = CLS_W'(i);
            end
        end
        free_hit = 1'b0;
        free_cls = '0;
        for (int i = CLASSES - 1; i >= 0; i--) begin
            if (off_reg < ADDR_W'((i + 1) * REGION_BYTES)) begin
                free_hit = 1'b1;
                free_cls = CLS_W'(i);
            end
        end
    end

    logic [SIZE_W-1:0] init_sz;
    logic              init_more;
    assign init_sz   = size_of(cls_reg);
    assign init_more = init_sz != '0 && k_reg < CNT_W'(MAX_CHUNKS)
        && (SUM_W'(acc_reg) + SUM_W'(init_sz)) <= SUM_W'(REGION_BYTES);

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        end_next        = end_reg;
        req_next        = req_reg;
        off_next        = off_reg;
        within_next     = within_reg;
        cls_next        = cls_reg;
        acc_next        = acc_reg;
        k_next          = k_reg;
        res_ok_next     = res_ok_reg;
        res_addr_next   = res_addr_reg;
        res_cls_next    = res_cls_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_ok_next       = m_ok_reg;
        m_addr_next     = m_addr_reg;
        m_cls_next      = m_cls_reg;
        m_status_next   = m_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = mem_base(cls_reg) + AW'(k_reg[PW-1:0]);
        mem_wdata       = OFF_W'(acc_reg);
        mem_raddr       = mem_base(alloc_cls) + AW'(head_reg[alloc_cls]);

        case (state_reg)
            S_IDLE: begin
                res_ok_next     = 1'b0;
                res_addr_next   = '0;
                res_cls_next    = '0;
                res_status_next = ST_OK;
                req_next        = s_req_size;
                off_next        = s_free_addr - heap_base_reg;
                cls_next        = '0;
                acc_next        = '0;
                k_next          = '0;
                if (s_valid) begin
                    case (op_t'(s_opcode))
                        OP_INIT:  state_next = S_INIT;
                        OP_ALLOC: state_next = S_ALLOC_SEL;
                        OP_FREE:  state_next = S_FREE_SEL;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_INIT: begin
                if (init_more) begin
                    mem_we   = 1'b1;
                    acc_next = acc_reg + END_W'(init_sz);
                    k_next   = k_reg + 1'b1;
                end else begin
                    head_next[cls_reg]  = '0;
                    tail_next[cls_reg]  = (k_reg == CNT_W'(MAX_CHUNKS)) ? '0 : k_reg[PW-1:0];
                    count_next[cls_reg] = k_reg;
                    end_next[cls_reg]   = acc_reg;
                    acc_next = '0;
                    k_next   = '0;
                    if (cls_reg == CLS_W'(CLASSES - 1)) begin
                        res_ok_next = 1'b1;
                        state_next  = S_RESP;
                    end else begin
                        cls_next = cls_reg + 1'b1;
                    end
                end
            end
            S_ALLOC_SEL: begin
                if (req_reg == '0) begin
                    res_status_next = ST_ZERO_SIZE;
                    state_next      = S_RESP;
                end else if (!alloc_hit) begin
                    res_status_next = ST_NO_FIT;
                    state_next      = S_RESP;
                end else begin
                    // pop: data comes back next cycle
                    head_next[alloc_cls]  = next_pos(head_reg[alloc_cls]);
                    count_next[alloc_cls] = count_reg[alloc_cls] - 1'b1;
                    cls_next   = alloc_cls;
                    state_next = S_ALLOC_DATA;
                end
            end
            S_ALLOC_DATA: begin
                res_ok_next   = 1'b1;
                res_cls_next  = cls_reg;
                res_addr_next = heap_base_reg + ADDR_W'(cls_reg) * ADDR_W'(REGION_BYTES)
                    + ADDR_W'(mem_q);
                state_next    = S_RESP;
            end
            S_FREE_SEL: begin
                cls_next    = free_cls;
                within_next = OFF_W'(off_reg - ADDR_W'(free_cls) * ADDR_W'(REGION_BYTES));
                if (free_hit) begin
                    state_next = S_FREE_PUSH;
                end else begin
                    res_status_next = ST_OUTSIDE;
                    state_next      = S_RESP;
                end
            end
            S_FREE_PUSH: begin
                mem_waddr = mem_base(cls_reg) + AW'(tail_reg[cls_reg]);
                mem_wdata = within_reg;
                if (END_W'(within_reg) >= end_reg[cls_reg]) begin
                    res_status_next = ST_OUTSIDE;
                end else if (count_reg[cls_reg] == CNT_W'(MAX_CHUNKS)) begin
                    // drop the address
                    res_cls_next    = cls_reg;
                    res_status_next = ST_FULL;
                end else begin
                    mem_we                = 1'b1;
                    tail_next[cls_reg]    = next_pos(tail_reg[cls_reg]);
                    count_next[cls_reg]   = count_reg[cls_reg] + 1'b1;
                    res_ok_next           = 1'b1;
                    res_cls_next          = cls_reg;
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_ok_next     = res_ok_reg;
                    m_addr_next   = res_addr_reg;
                    m_cls_next    = res_cls_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_ok          = m_ok_reg;
    assign m_out_addr    = m_addr_reg;
    assign m_class_index = CLS_OUT_W'(m_cls_reg);
    assign m_status      = m_status_reg;

endmodule

// File: rtl/slab_checker.sv
// Port-level checks for the slab size class allocator, bound to the top level.
// Depends on slab_pkg and slab_size_class_allocator_defines.svh.
`include "slab_size_class_allocator_defines.svh"

module slab_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic                           m_ok,
    input logic [slab_pkg::ADDR_W-1:0]    m_out_addr,
    input logic [slab_pkg::CLS_OUT_W-1:0] m_class_index,
    input logic [slab_pkg::STAT_W-1:0]    m_status
);
    import slab_pkg::*;

    `SLAB_ASSERT_NEXT(a_hold_beat, m_valid && !m_ready, m_valid && $stable(m_out_addr))
    `SLAB_ASSERT_NOW(a_ok_status, m_valid && m_ok, m_status == ST_OK)
    `SLAB_ASSERT_NOW(a_fail_addr, m_valid && !m_ok, m_out_addr == '0)
    `SLAB_ASSERT_NOW(a_nofit_cls, m_valid && (m_status == ST_NO_FIT || m_status == ST_ZERO_SIZE), m_class_index == '0)

endmodule

bind slab_size_class_allocator slab_checker u_slab_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_ok          (m_ok),
    .m_out_addr    (m_out_addr),
    .m_class_index (m_class_index),
    .m_status      (m_status)
);

// File: dv/tb_slab_size_class_allocator.sv
// Self-checking testbench for the slab size class allocator.
// Drives the valid/ready channels and the config port; depends on slab_pkg and the RTL top.
module tb_slab_size_class_allocator;
    import slab_pkg::*;

    localparam int NCLS = DEF_CLASSES;
    localparam int RBYTES = DEF_REGION_BYTES;
    localparam int MAXCH = DEF_MAX_CHUNKS;

    typedef struct {
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        cls;
        status_t           st;
    } resp_t;

    typedef struct {
        op_t               op;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        bit                lit;
        resp_t             want;
    } row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_opcode = '0;
    logic [REQ_W-1:0] s_req_size = '0;
    logic [ADDR_W-1:0] s_free_addr = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_ok;
    logic [ADDR_W-1:0] m_out_addr;
    logic [CLS_OUT_W-1:0] m_class_index;
    logic [STAT_W-1:0] m_status;

    slab_size_class_allocator uut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // allocator shadow state
    logic [ADDR_W-1:0] base_sh;
    logic [SIZE_W-1:0] size_sh [NCLS];
    logic [17:0]       chunk_fifo [NCLS][$];
    logic [SIZE_W-1:0] end_sh [NCLS];

    resp_t pending_q[$];
    logic [ADDR_W-1:0] live_addrs[$];
    int errors = 0;
    int beats_in = 0;
    int beats_out = 0;
    int inits_seen = 0;
    bit calm = 0;

    function automatic resp_t allocator_step(op_t op, logic [REQ_W-1:0] req,
                                             logic [ADDR_W-1:0] addr);
        resp_t r;
        logic [ADDR_W-1:0] off;
        int n;
        r = '{ok: 1'b0, addr: '0, cls: '0, st: ST_OK};
        case (op)
            OP_INIT: begin
                for (int c = 0; c < NCLS; c++) begin
                    chunk_fifo[c].delete();
                    n = (size_sh[c] != 0) ? RBYTES / size_sh[c] : 0;
                    if (n > MAXCH) n = MAXCH;
                    for (int k = 0; k < n; k++) chunk_fifo[c].push_back(18'(k * size_sh[c]));
                    end_sh[c] = SIZE_W'(n * size_sh[c]);
                end
                r.ok = 1'b1;
            end
            OP_ALLOC: begin
                if (req == 0) begin
                    r.st = ST_ZERO_SIZE;
                end else begin
                    r.st = ST_NO_FIT;
                    for (int c = 0; c < NCLS; c++) begin
                        if ({13'd0, size_sh[c]} >= req && chunk_fifo[c].size() > 0) begin
                            r.addr = base_sh + ADDR_W'(c * RBYTES) + chunk_fifo[c].pop_front();
                            r.ok = 1'b1;
                            r.cls = 2'(c);
                            r.st = ST_OK;
                            break;
                        end
                    end
                end
            end
            OP_FREE: begin
                off = addr - base_sh;
                if (off / RBYTES < NCLS && (off % RBYTES) < end_sh[off / RBYTES]) begin
                    r.cls = 2'(off / RBYTES);
                    if (chunk_fifo[r.cls].size() < MAXCH) begin
                        chunk_fifo[r.cls].push_back(18'(off % RBYTES));
                        r.ok = 1'b1;
                    end else begin
                        r.st = ST_FULL;
                    end
                end else begin
                    r.st = ST_OUTSIDE;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_beat(op_t op, logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
                             bit lit, resp_t want);
        resp_t r;
        if (!calm && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_req_size <= req;
        s_free_addr <= addr;
        do @(posedge aclk); while (!s_ready);
        r = allocator_step(op, req, addr);
        pending_q.push_back(lit ? want : r);
        beats_in++;
        if (op == OP_INIT) inits_seen++;
        if (op == OP_ALLOC && r.ok) live_addrs.push_back(r.addr);
    endtask

    // hold until every result is back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_regs(logic [ADDR_W-1:0] base, logic [SIZE_W-1:0] sz [NCLS]);
        for (int i = 0; i <= NCLS; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= (i == CFG_HEAP_BASE) ? base : ADDR_W'(sz[i-1]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        base_sh = base;
        for (int c = 0; c < NCLS; c++) size_sh[c] = sz[c];
    endtask

    task automatic random_beat();
        int r;
        int k;
        logic [REQ_W-1:0] req;
        logic [ADDR_W-1:0] addr;
        resp_t none;
        none = '{ok: 1'b0, addr: '0, cls: '0, st: ST_OK};
        r = $urandom_range(0, 99);
        req = {$urandom};
        addr = {$urandom, $urandom};
        if (r < 45) begin
            k = $urandom_range(0, 9);
            if (k == 0) req = 0;
            else if (k > 1) req = $urandom_range(1, RBYTES + 16);
            send_beat(OP_ALLOC, req, addr, 0, none);
        end else if (r < 90) begin
            k = $urandom_range(0, 9);
            if (k < 7 && live_addrs.size() > 0) begin
                k = $urandom_range(0, live_addrs.size() - 1);
                addr = live_addrs[k];
                // keep some entries around so double frees happen
                if ($urandom_range(0, 3) != 0) live_addrs.delete(k);
            end else if (k < 9) begin
                addr = base_sh + ADDR_W'($urandom_range(0, NCLS * RBYTES + 64));
            end
            send_beat(OP_FREE, req, addr, 0, none);
        end else if (r < 94) begin
            live_addrs.delete();
            send_beat(OP_INIT, req, addr, 0, none);
        end else begin
            send_beat(OP_NONE, req, addr, 0, none);
        end
    endtask

    // result side: random backpressure and in-order compare
    always @(posedge aclk) begin
        resp_t e;
        if (aresetn && m_valid && m_ready) begin
            beats_out++;
            if (pending_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (m_ok !== e.ok) begin
                    $error("ok: expected %0d actual %0d", e.ok, m_ok);
                    errors++;
                end
                if (m_out_addr !== e.addr) begin
                    $error("out_addr: expected %h actual %h", e.addr, m_out_addr);
                    errors++;
                end
                if (m_class_index !== e.cls) begin
                    $error("class_index: expected %0d actual %0d", e.cls, m_class_index);
                    errors++;
                end
                if (m_status !== e.st) begin
                    $error("status: expected %0d actual %0d", e.st, m_status);
                    errors++;
                end
            end
        end
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 33);
    end

    initial begin
        #4000000;
        $display("tb_slab_size_class_allocator: FAIL");
        $finish;
    end

    initial begin
        row_t dir_tab[$];
        logic [SIZE_W-1:0] sz [NCLS];
        logic [SIZE_W-1:0] tmp;
        logic [ADDR_W-1:0] base;
        localparam logic [ADDR_W-1:0] R = ADDR_W'(RBYTES);
        localparam logic [ADDR_W-1:0] ONES = '1;

        base_sh = '0;
        for (int c = 0; c < NCLS; c++) begin
            size_sh[c] = SIZE_W'(16 << c);
            end_sh[c] = '0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        sz = '{19'd16, 19'd32, 19'd64, 19'd128};
        write_regs('0, sz);

        dir_tab.push_back('{OP_ALLOC, 32'd5, '0, 1, '{1'b0, '0, 2'd0, ST_NO_FIT}});
        dir_tab.push_back('{OP_FREE, '0, '0, 1, '{1'b0, '0, 2'd0, ST_OUTSIDE}});
        dir_tab.push_back('{OP_NONE, '1, ONES, 1, '{1'b0, '0, 2'd0, ST_OK}});
        dir_tab.push_back('{OP_ALLOC, '0, ONES, 1, '{1'b0, '0, 2'd0, ST_ZERO_SIZE}});
        dir_tab.push_back('{OP_INIT, '1, ONES, 1, '{1'b1, '0, 2'd0, ST_OK}});
        dir_tab.push_back('{OP_FREE, '0, 48'd32, 1, '{1'b0, '0, 2'd0, ST_FULL}});
        dir_tab.push_back('{OP_FREE, '0, 3 * R, 0, '{1'b0, '0, 2'd0, ST_OK}});
        dir_tab.push_back('{OP_ALLOC, 32'd1, '0, 1, '{1'b1, '0, 2'd0, ST_OK}});
        dir_tab.push_back('{OP_ALLOC, 32'd16, '0, 1, '{1'b1, 48'd16, 2'd0, ST_OK}});
        dir_tab.push_back('{OP_ALLOC, 32'd17, '0, 1, '{1'b1, R, 2'd1, ST_OK}});
        dir_tab.push_back('{OP_ALLOC, 32'd128, '0, 1, '{1'b1, 3 * R, 2'd3, ST_OK}});
        dir_tab.push_back('{OP_ALLOC, 32'd129, '0, 1, '{1'b0, '0, 2'd0, ST_NO_FIT}});
        dir_tab.push_back('{OP_ALLOC, '1, '0, 1, '{1'b0, '0, 2'd0, ST_NO_FIT}});
        dir_tab.push_back('{OP_FREE, '0, 48'd16, 1, '{1'b1, '0, 2'd0, ST_OK}});
        dir_tab.push_back('{OP_FREE, '0, 4 * R, 1, '{1'b0, '0, 2'd0, ST_OUTSIDE}});
        dir_tab.push_back('{OP_FREE, '0, 4 * R - 1, 0, '{1'b0, '0, 2'd0, ST_OK}});
        dir_tab.push_back('{OP_FREE, '0, ONES, 1, '{1'b0, '0, 2'd0, ST_OUTSIDE}});
        dir_tab.push_back('{OP_FREE, '0, R + 5, 0, '{1'b0, '0, 2'd0, ST_OK}});
        dir_tab.push_back('{OP_ALLOC, 32'd64, '0, 0, '{1'b0, '0, 2'd0, ST_OK}});
        foreach (dir_tab[i])
            send_beat(dir_tab[i].op, dir_tab[i].req, dir_tab[i].addr,
                      dir_tab[i].lit, dir_tab[i].want);

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            live_addrs.delete();
            base = {$urandom, $urandom};
            for (int c = 0; c < NCLS; c++) sz[c] = SIZE_W'($urandom_range(2048, RBYTES));
            if (ph == 0) begin
                base = '0;
                sz = '{19'd262144, 19'd262144, 19'd262144, 19'd262144};
            end else if (ph == 1) begin
                base = ONES;
            end
            // ascending order except in the unsorted phase
            if (ph != 2) begin
                for (int i = 0; i < NCLS; i++)
                    for (int j = i + 1; j < NCLS; j++)
                        if (sz[j] < sz[i]) begin
                            tmp = sz[i];
                            sz[i] = sz[j];
                            sz[j] = tmp;
                        end
            end
            write_regs(base, sz);
            calm = (ph == 3);
            send_beat(OP_INIT, '0, '0, 0, '{1'b0, '0, 2'd0, ST_OK});
            for (int n = 0; n < 132; n++) begin
                if (ph == 4 && n == 60) drain();
                random_beat();
            end
        end
        calm = 0;
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Sent %0d beats (%0d initializes) over 8 register settings, checked %0d results.",
                 beats_in, inits_seen, beats_out);
        if (errors == 0)
            $display("tb_slab_size_class_allocator: PASS");
        else
            $display("tb_slab_size_class_allocator: FAIL");
        $finish;
    end

endmodule
